FILE: rtl/core/dict_enc_pkg.sv
// ----------------------------------------------------------------------------
// dict_enc_pkg
// Shared types and codes for the dictionary encoder core: function codes,
// result status codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dict_enc_pkg;

   // Function carried by each request beat.
   typedef enum logic [1:0] {
      FUNC_ENCODE = 2'd0,
      FUNC_FIND   = 2'd1,
      FUNC_DECODE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   // Status reported with each response beat.
   typedef enum logic [2:0] {
      STAT_EXISTING  = 3'd0,
      STAT_ADDED     = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_BAD_CODE  = 3'd4
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DEC_RD,
      ST_FINAL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the request beat and reset the scan
      logic scan;     // advance the key scan by one entry
      logic dec_rd;   // read the entry addressed by the decode code
      logic finish;   // produce the response and update the dictionary
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;  // the scan has hit or has run past the last entry
      logic out_free;   // the response register can take a new beat
   } dp_sts_type;

endpackage

FILE: rtl/core/dict_enc_ctrl.sv
// ----------------------------------------------------------------------------
// dict_enc_ctrl
// Controller state machine of the dictionary encoder. It takes a request
// beat when idle, steers the datapath through a key scan or a decode read,
// and lets the result go out once the response register is free.
// ----------------------------------------------------------------------------
module dict_enc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [1:0]                req_func,
   output logic                      req_stall,
   input  dict_enc_pkg::dp_sts_type  sts,
   output dict_enc_pkg::ctl_cmd_type cmd
);
   import dict_enc_pkg::*;

   state_type state_ff;
   state_type state_in;
   func_type  func_sel;

   assign func_sel = func_type'(req_func);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (func_sel) inside
                  FUNC_ENCODE, FUNC_FIND: state_in = ST_SCAN;
                  FUNC_DECODE:            state_in = ST_DEC_RD;
                  default:                state_in = ST_FINAL;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = !sts.scan_done;
            if (sts.scan_done && sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DEC_RD: begin
            cmd.dec_rd = 1'b1;
            state_in   = ST_FINAL;
         end
         ST_FINAL: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/dict_enc_dpath.sv
// ----------------------------------------------------------------------------
// dict_enc_dpath
// Datapath of the dictionary encoder: the key store indexed by code, the
// entry count, the scan pointer with its registered read pipeline, and the
// response register.
// ----------------------------------------------------------------------------
module dict_enc_dpath #(
   parameter int DEPTH     = 256,
   parameter int KEY_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dict_enc_pkg::ctl_cmd_type cmd,
   output dict_enc_pkg::dp_sts_type  sts,
   input  logic [1:0]                req_func,
   input  logic [31:0]               req_key,
   input  logic [7:0]                req_code_in,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [8:0]                rsp_code,
   output logic                      rsp_found,
   output logic [31:0]               rsp_key_out,
   output logic [2:0]                rsp_status
);
   import dict_enc_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMPW  = (CNT_W > 8) ? CNT_W : 8;

   // Key store, one entry per assigned code.
   logic [KEY_WIDTH-1:0] mem [DEPTH];

   // Captured request.
   func_type             func_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [7:0]           cin_ff;

   // Dictionary and scan control.
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     pidx_ff;
   logic                 pvld_ff;
   logic [KEY_WIDTH-1:0] rdata_ff;

   // Response register.
   logic                 rsp_valid_ff;
   logic [8:0]           code_ff;
   logic                 found_ff;
   logic [31:0]          kout_ff;
   status_type           status_ff;

   logic [KEY_WIDTH+31:0] key_wide;
   logic [KEY_WIDTH+31:0] rdata_wide;
   logic [KEY_WIDTH-1:0]  key_trim;
   logic                  more;
   logic                  hit;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  has_room;
   logic                  wr_en;
   logic [CNT_W:0]        count_p1;
   logic [CMPW-1:0]       cin_x;
   logic                  cin_ok;
   logic [8:0]            code_in;
   logic                  found_in;
   logic [31:0]           kout_in;
   status_type            status_in;

   // Key bits above the key width are dropped; narrow keys read back zero-extended.
   assign key_wide   = {KEY_WIDTH'(0), req_key};
   assign key_trim   = key_wide[KEY_WIDTH-1:0];
   assign rdata_wide = {32'd0, rdata_ff};

   // Scan status: the registered read of the previous entry is compared here.
   assign more     = idx_ff < count_ff;
   assign hit      = pvld_ff && (rdata_ff == key_ff);
   assign has_room = count_ff < CNT_W'(DEPTH);
   assign count_p1 = {1'b0, count_ff} + (CNT_W + 1)'(1);
   assign cin_x    = CMPW'(cin_ff);
   assign cin_ok   = (cin_x < CMPW'(count_ff)) && (cin_x < CMPW'(DEPTH));

   assign sts.scan_done = hit || (!pvld_ff && !more);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // Memory read port is shared by the scan and the decode lookup.
   assign rd_en   = (cmd.scan && more) || cmd.dec_rd;
   assign rd_addr = cmd.dec_rd ? AW'(cin_ff) : idx_ff[AW-1:0];

   // A new key is appended at the next free code.
   assign wr_en = cmd.finish && (func_ff == FUNC_ENCODE) && !hit && has_room;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= key_ff;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func_type'(req_func);
         key_ff  <= key_trim;
         cin_ff  <= req_code_in;
      end
   end

   // Scan pointer and read pipeline tag.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         pvld_ff <= 1'b0;
      end else if (cmd.load) begin
         idx_ff  <= '0;
         pvld_ff <= 1'b0;
      end else if (cmd.scan) begin
         pvld_ff <= more;
         if (more) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         pidx_ff <= idx_ff;
      end
   end

   // Entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish && (func_ff == FUNC_CLEAR)) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_p1[CNT_W-1:0];
      end
   end

   // Response fields for the item that finishes this cycle.
   always_comb begin
      code_in   = '0;
      found_in  = 1'b0;
      kout_in   = '0;
      status_in = STAT_EXISTING;
      case (func_ff) inside
         FUNC_ENCODE, FUNC_FIND: begin
            if (hit) begin
               code_in  = 9'(pidx_ff);
               found_in = 1'b1;
            end else if (func_ff == FUNC_FIND) begin
               code_in   = 9'(count_p1);
               status_in = STAT_NOT_FOUND;
            end else if (has_room) begin
               code_in   = 9'(count_ff);
               status_in = STAT_ADDED;
            end else begin
               code_in   = 9'(count_p1);
               status_in = STAT_FULL;
            end
         end
         FUNC_DECODE: begin
            code_in = 9'(cin_ff);
            if (cin_ok) begin
               found_in = 1'b1;
               kout_in  = rdata_wide[31:0];
            end else begin
               status_in = STAT_BAD_CODE;
            end
         end
         default: begin
            status_in = STAT_EXISTING;
         end
      endcase
   end

   // Response register: holds its beat until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         code_ff   <= code_in;
         found_ff  <= found_in;
         kout_ff   <= kout_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_code    = code_ff;
   assign rsp_found   = found_ff;
   assign rsp_key_out = kout_ff;
   assign rsp_status  = status_ff;

endmodule

FILE: rtl/core/dictionary_encoder_core.sv
// ----------------------------------------------------------------------------
// dictionary_encoder_core
// Column dictionary encoder with sequential codes: encode, find, decode
// and clear over a key store that doubles as the code-to-key table.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_func, req_key, req_code_in) is taken when req_valid
//   is high and req_stall is low; each request gives one response beat on
//   the rsp_ channel, in request order. One request is worked on at a time.
//   Encode and find scan the stored keys one entry per cycle through the
//   single read port, up to the matching position or, on a miss, through
//   every stored entry; decode reads the addressed entry once, and clear
//   goes straight to the result. req_stall drops in the cycle after the
//   response register loads, so a new request may be taken while the
//   previous response still waits.
//   If the receiver holds rsp_stall high, the response beat stays put and
//   the next item waits at its last step until the register is free.
//   Reset empties the dictionary at once (entry count to zero); the key
//   store itself needs no clearing pass.
// ----------------------------------------------------------------------------
module dictionary_encoder_core #(
   parameter int DEPTH     = 256,
   parameter int KEY_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_key,
   input  logic [7:0]  req_code_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_code,
   output logic        rsp_found,
   output logic [31:0] rsp_key_out,
   output logic [2:0]  rsp_status
);
   import dict_enc_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // Controller.
   dict_enc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath.
   dict_enc_dpath #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_func    (req_func),
      .req_key     (req_key),
      .req_code_in (req_code_in),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_code    (rsp_code),
      .rsp_found   (rsp_found),
      .rsp_key_out (rsp_key_out),
      .rsp_status  (rsp_status)
   );

`ifndef SYNTH
   // Once a request is taken, no other is taken until it has finished.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in progress");

   // A result is only produced when the response register can take it.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free)
      else $error("response overwritten before it was taken");

   // A finished item always shows up as a response beat.
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished item produced no response beat");

   // A newly added key was not found before.
   a_added_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_ADDED)) |-> !rsp_found)
      else $error("added key reported as found");
`endif

endmodule
